>>> sv/fht_pkg.sv
// Package with types and constants shared by the fragment hole tracker.
package fht_pkg;
   localparam int MAX_HOLES = 16;
   localparam int POS_BITS = 32;
   localparam int IDX_BITS = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
   localparam int CNT_BITS = $clog2(MAX_HOLES + 1);
   localparam int ADDR_BITS = 3;
   localparam logic [ADDR_BITS-1:0] ADDR_TOTAL_SIZE = 3'd0;
   localparam logic [ADDR_BITS-1:0] ADDR_MAX_FRAG = 3'd4;
   localparam logic [15:0] MAX_FRAG_RESET = 16'd1024;

   typedef struct packed {
      logic        mode;
      logic [31:0] fragment_start;
      logic [15:0] fragment_length;
   } req_type;

   typedef struct packed {
      logic [31:0] next_missing_start;
      logic [15:0] next_missing_length;
      logic        all_received;
      logic        table_overflow;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_WALK,
      ST_REPORT,
      ST_READ0
   } state_type;
endpackage

>>> sv/fragment_hole_tracker.sv
// Top level of the fragment hole tracker: hole table in memory and its sequencer.
//
// Usage: pulse req_start with req_data while busy is low. mode 1 starts a new
// message (one hole covering total_size bytes); mode 0 cuts the fragment range
// out of the hole table. Each transaction produces exactly one result on
// rsp_data, marked by rsp_valid for one cycle; the receiver cannot stall it.
// total_size and the reported length cap are written through the csr_ APB port
// at byte addresses 0 and 4; the user is to write them only while the block is
// idle, and the block itself does not enforce this. A new-message item goes
// through ST_READ0 and ST_REPORT. A fragment is checked in ST_CHECK, each hole
// read once, then walked in ST_WALK and reported through ST_READ0 and
// ST_REPORT; an overflow ends the check early. busy falls in the cycle that
// carries the result, so the next item can be accepted at its end.
// The hole table sits in a single-port-read memory, so every hole is read once
// to check for a split that would overflow, then read again while the trimmed
// table is written back in order. Entry zero is then read for the report.
// Reset clears the hole count (all_received), the control state and the
// CSR registers to their defaults; the hole memory needs no clearing as only
// entries below the count are ever read.
module fragment_hole_tracker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_start,
   input  fht_pkg::req_type       req_data,
   output logic                   busy,
   output logic                   rsp_valid,
   output fht_pkg::rsp_type       rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [fht_pkg::ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   localparam int PB = fht_pkg::POS_BITS;
   localparam int IB = fht_pkg::IDX_BITS;
   localparam int CB = fht_pkg::CNT_BITS;

   logic [2*PB-1:0] mem [fht_pkg::MAX_HOLES];
   logic [2*PB-1:0] rd_ff;

   fht_pkg::state_type state_ff, state_in;
   logic [31:0] total_ff;
   logic [15:0] maxf_ff;
   logic [CB-1:0] count_ff, count_in;
   logic [CB-1:0] rdi_ff, rdi_in;
   logic [CB-1:0] wri_ff, wri_in;
   logic rdv_ff, rdv_in;
   logic ovf_ff, ovf_in;
   logic [PB-1:0] s_ff;
   logic [PB:0] e_ff;
   logic [PB-1:0] pend_b_ff, pend_b_in;
   logic [PB-1:0] pend_f_ff, pend_f_in;
   logic pend_ff, pend_in;
   logic rsp_valid_ff;
   fht_pkg::rsp_type rsp_ff;

   logic cfg_wr;
   logic accept;
   logic we;
   logic [IB-1:0] waddr;
   logic [2*PB-1:0] wdata;
   logic [PB-1:0] hb, hf;
   logic meets, left, right, split;

   assign cfg_wr = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr)
         fht_pkg::ADDR_TOTAL_SIZE: csr_prdata = total_ff;
         fht_pkg::ADDR_MAX_FRAG: csr_prdata = {16'd0, maxf_ff};
         default: csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= 32'd0;
         maxf_ff <= fht_pkg::MAX_FRAG_RESET;
      end else if (cfg_wr) begin
         if (csr_paddr == fht_pkg::ADDR_TOTAL_SIZE) total_ff <= csr_pwdata;
         if (csr_paddr == fht_pkg::ADDR_MAX_FRAG) maxf_ff <= csr_pwdata[15:0];
      end
   end

   assign busy = (state_ff != fht_pkg::ST_IDLE);
   assign accept = req_start & ~busy;

   assign hb = rd_ff[2*PB-1:PB];
   assign hf = rd_ff[PB-1:0];
   assign meets = ({1'b0, hb} < e_ff) && (s_ff < hf) && (e_ff != {1'b0, s_ff});
   assign left = meets && (hb < s_ff);
   assign right = meets && (e_ff < {1'b0, hf});
   assign split = left && right;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fht_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_data.mode) state_in = fht_pkg::ST_READ0;
               else state_in = fht_pkg::ST_CHECK;
            end
         end
         fht_pkg::ST_CHECK: begin
            if (rdv_ff && split && (count_ff >= CB'(fht_pkg::MAX_HOLES)))
               state_in = fht_pkg::ST_READ0;
            else if (rdv_ff && (rdi_ff == count_ff)) state_in = fht_pkg::ST_WALK;
            else if (!rdv_ff && (rdi_ff == count_ff)) state_in = fht_pkg::ST_WALK;
         end
         fht_pkg::ST_WALK: begin
            if (!rdv_ff && !pend_ff && (rdi_ff == count_ff))
               state_in = fht_pkg::ST_READ0;
         end
         fht_pkg::ST_READ0: state_in = fht_pkg::ST_REPORT;
         fht_pkg::ST_REPORT: state_in = fht_pkg::ST_IDLE;
         default: state_in = fht_pkg::ST_IDLE;
      endcase
   end

   // Datapath control: new-message write, reads, write-back of the trimmed table.
   always_comb begin
      count_in = count_ff;
      rdi_in = rdi_ff;
      wri_in = wri_ff;
      rdv_in = 1'b0;
      ovf_in = ovf_ff;
      pend_in = pend_ff;
      pend_b_in = pend_b_ff;
      pend_f_in = pend_f_ff;
      we = 1'b0;
      waddr = wri_ff[IB-1:0];
      wdata = {hb, hf};
      case (state_ff)
         fht_pkg::ST_IDLE: begin
            rdi_in = '0;
            wri_in = '0;
            ovf_in = 1'b0;
            pend_in = 1'b0;
            if (accept && req_data.mode) begin
               we = (total_ff[PB-1:0] != '0);
               waddr = '0;
               wdata = {{PB{1'b0}}, total_ff[PB-1:0]};
               count_in = we ? CB'(1) : '0;
            end
         end
         fht_pkg::ST_CHECK: begin
            if (rdv_ff && split && (count_ff >= CB'(fht_pkg::MAX_HOLES))) begin
               ovf_in = 1'b1;
            end else if (rdi_ff != count_ff) begin
               rdv_in = 1'b1;
               rdi_in = rdi_ff + CB'(1);
            end else begin
               rdi_in = '0;
            end
         end
         fht_pkg::ST_WALK: begin
            // A pending right part is written back from its register while the next read is issued.
            if (pend_ff) begin
               we = 1'b1;
               wdata = {pend_b_ff, pend_f_ff};
               wri_in = wri_ff + CB'(1);
               pend_in = 1'b0;
               if (rdi_ff != count_ff) begin
                  rdv_in = 1'b1;
                  rdi_in = rdi_ff + CB'(1);
               end
            end else begin
               if (rdv_ff) begin
                  if (!meets) begin
                     we = 1'b1;
                     wri_in = wri_ff + CB'(1);
                  end else begin
                     if (left) begin
                        we = 1'b1;
                        wdata = {hb, s_ff};
                        wri_in = wri_ff + CB'(1);
                     end
                     if (right) begin
                        if (left) begin
                           pend_in = 1'b1;
                           pend_b_in = e_ff[PB-1:0];
                           pend_f_in = hf;
                        end else begin
                           we = 1'b1;
                           wdata = {e_ff[PB-1:0], hf};
                           wri_in = wri_ff + CB'(1);
                        end
                     end
                  end
               end
               if (!(rdv_ff && split) && (rdi_ff != count_ff)) begin
                  rdv_in = 1'b1;
                  rdi_in = rdi_ff + CB'(1);
               end
               if (!rdv_ff && !pend_ff && (rdi_ff == count_ff)) count_in = wri_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // After a split the write address can catch up with the read address; both
   // then act at the same edge and the read returns the old word, which has
   // still to be walked, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (state_ff == fht_pkg::ST_READ0) rd_ff <= mem[0];
      else rd_ff <= mem[rdi_ff[IB-1:0]];
      if (accept) begin
         s_ff <= req_data.fragment_start[PB-1:0];
         e_ff <= {1'b0, req_data.fragment_start[PB-1:0]} + (PB+1)'(req_data.fragment_length);
      end
      pend_b_ff <= pend_b_in;
      pend_f_ff <= pend_f_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fht_pkg::ST_IDLE;
         count_ff <= '0;
         rdi_ff <= '0;
         wri_ff <= '0;
         rdv_ff <= 1'b0;
         ovf_ff <= 1'b0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdi_ff <= rdi_in;
         wri_ff <= wri_in;
         rdv_ff <= rdv_in;
         ovf_ff <= ovf_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= (state_ff == fht_pkg::ST_REPORT);
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (state_ff == fht_pkg::ST_REPORT) begin
         rsp_ff.table_overflow <= ovf_ff;
         if (count_ff == '0) begin
            rsp_ff.next_missing_start <= 32'd0;
            rsp_ff.next_missing_length <= 16'd0;
            rsp_ff.all_received <= 1'b1;
         end else begin
            rsp_ff.next_missing_start <= 32'(hb);
            rsp_ff.all_received <= 1'b0;
            if ((hf - hb) > PB'(maxf_ff)) rsp_ff.next_missing_length <= maxf_ff;
            else rsp_ff.next_missing_length <= 16'(hf - hb);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(fht_pkg::MAX_HOLES))
      else $error("hole count exceeds table size");
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid))
      else $error("two results in a row");
   a_rsp_after_report: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fht_pkg::ST_REPORT) |=> rsp_valid)
      else $error("report without result");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == fht_pkg::ST_IDLE && req_start) |=> busy)
      else $error("accepted item not processed");
`endif
endmodule
